[design/bpcn_pkg.sv]
// ----------------------------------------------------------------------------
// bpcn_pkg: shared definitions for the corrected box-plus check node
// Field widths, correction tables and the correction lookup functions.
// ----------------------------------------------------------------------------
package bpcn_pkg;

	localparam int LLR_WIDTH = 16;
	localparam int FRAC_BITS = 8;

	// magnitudes of a, b, a+b and a-b all fit here
	localparam int MAG_W  = LLR_WIDTH + 1;
	// correction levels are all below 1.0
	localparam int CORR_W = FRAC_BITS + 1;
	// signed width of base term plus correction difference
	localparam int SUM_W  = ((MAG_W > CORR_W) ? MAG_W : CORR_W) + 2;

	// table constants are given in units of 1/10000
	localparam int TEN_K  = 10000;
	localparam int ONE_FX = 1 << FRAC_BITS;
	localparam int STEP_N = 7;
	localparam int LIN_N  = 5;

	// thresholds: floor(t * 2^F); levels and intercepts: round half up
	localparam int STEP_EDGE [STEP_N] = '{
		(1960 * ONE_FX) / TEN_K,  (4330 * ONE_FX) / TEN_K,
		(7100 * ONE_FX) / TEN_K,  (10500 * ONE_FX) / TEN_K,
		(15080 * ONE_FX) / TEN_K, (22520 * ONE_FX) / TEN_K,
		(45000 * ONE_FX) / TEN_K
	};
	localparam int STEP_LEVEL [STEP_N] = '{
		(6500 * ONE_FX + TEN_K / 2) / TEN_K, (5500 * ONE_FX + TEN_K / 2) / TEN_K,
		(4500 * ONE_FX + TEN_K / 2) / TEN_K, (3500 * ONE_FX + TEN_K / 2) / TEN_K,
		(2500 * ONE_FX + TEN_K / 2) / TEN_K, (1500 * ONE_FX + TEN_K / 2) / TEN_K,
		(500 * ONE_FX + TEN_K / 2) / TEN_K
	};
	localparam int LIN_EDGE [LIN_N] = '{
		(5000 * ONE_FX) / TEN_K,  (16000 * ONE_FX) / TEN_K,
		(22000 * ONE_FX) / TEN_K, (32000 * ONE_FX) / TEN_K,
		(44000 * ONE_FX) / TEN_K
	};
	localparam int LIN_ICPT [LIN_N] = '{
		(7000 * ONE_FX + TEN_K / 2) / TEN_K, (5750 * ONE_FX + TEN_K / 2) / TEN_K,
		(3750 * ONE_FX + TEN_K / 2) / TEN_K, (2375 * ONE_FX + TEN_K / 2) / TEN_K,
		(1375 * ONE_FX + TEN_K / 2) / TEN_K
	};

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_STEP = 2'd1,
		MODE_LIN  = 2'd2,
		MODE_RSVD = 2'd3
	} corr_mode_t;

	typedef logic [MAG_W-1:0]  mag_t;
	typedef logic [CORR_W-1:0] corr_t;

	// first band whose threshold covers mag wins
	function automatic corr_t step_corr(mag_t mag);
		corr_t res;
		res = '0;
		for (int i = STEP_N - 1; i >= 0; i--) begin
			if (64'(mag) <= 64'(STEP_EDGE[i])) begin
				res = CORR_W'(STEP_LEVEL[i]);
			end
		end
		return res;
	endfunction

	// band i: intercept minus mag >> (i+1), floored at zero
	function automatic corr_t lin_corr(mag_t mag);
		corr_t  res;
		longint v;
		res = '0;
		v   = 0;
		for (int i = LIN_N - 1; i >= 0; i--) begin
			if (64'(mag) <= 64'(LIN_EDGE[i])) begin
				v   = longint'(LIN_ICPT[i]) - longint'(64'(mag) >> (i + 1));
				res = (v < 0) ? '0 : CORR_W'(v);
			end
		end
		return res;
	endfunction

	function automatic corr_t corr_of(corr_mode_t mode, mag_t mag);
		corr_t res;
		unique case (mode)
			MODE_STEP: res = step_corr(mag);
			MODE_LIN:  res = lin_corr(mag);
			default:   res = '0;
		endcase
		return res;
	endfunction

endpackage

[design/boxplus_check_node_corrected.sv]
// ----------------------------------------------------------------------------
// boxplus_check_node_corrected: LDPC check-node box-plus with correction
// sign(a)*sign(b)*min(|a|,|b|) + f(|a+b|) - f(|a-b|), saturated, where f is
// none, a step table or a piecewise-linear table, chosen by a mode register.
// ----------------------------------------------------------------------------
//
//   port group   direction  handshake              payload
//   -----------  ---------  ---------------------  -------------------
//   input        in         in_valid / in_ready    llr_a, llr_b
//   result       out        out_valid / out_ready  llr_out
//   mode write   in         cfg_we                 cfg_wdata
//
// One request per cycle sustained while out_ready is high; path: input register,
// then result register, all arithmetic in one pass between them.
// A stalled result holds in the result register; the input register still
// takes a request while the result register is free or being drained.
// arst_n clears both valid bits and sets the mode to piecewise linear.
// Mode writes take effect on the next cycle, no handshake.
module boxplus_check_node_corrected (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [bpcn_pkg::LLR_WIDTH-1:0] llr_a,
	input  logic signed [bpcn_pkg::LLR_WIDTH-1:0] llr_b,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [bpcn_pkg::LLR_WIDTH-1:0] llr_out,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_wdata
);
	import bpcn_pkg::*;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'(1) << (LLR_WIDTH - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	corr_mode_t mode_q;

	logic                          valid_s1;
	logic signed [LLR_WIDTH-1:0]   a_s1;
	logic signed [LLR_WIDTH-1:0]   b_s1;
	logic                          valid_s2;
	logic signed [LLR_WIDTH-1:0]   out_s2;

	logic                          adv_s1;
	logic                          adv_s2;

	logic signed [MAG_W-1:0]       a_ext;
	logic signed [MAG_W-1:0]       b_ext;
	logic signed [MAG_W-1:0]       sum_ab;
	logic signed [MAG_W-1:0]       dif_ab;
	mag_t                          mag_a;
	mag_t                          mag_b;
	mag_t                          mag_sum;
	mag_t                          mag_dif;
	mag_t                          mag_min;
	logic                          neg;
	corr_t                         corr_sum;
	corr_t                         corr_dif;
	logic signed [SUM_W-1:0]       base;
	logic signed [SUM_W-1:0]       total;
	logic signed [LLR_WIDTH-1:0]   sat;

	// mode register; the user must write it only while the node is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LIN;
		end else if (cfg_we) begin
			mode_q <= corr_mode_t'(cfg_wdata);
		end
	end

	// advance the result register when empty or drained; the input
	// register advances when the result register can take its request
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			a_s1 <= llr_a;
			b_s1 <= llr_b;
		end
		if (adv_s2 && valid_s1) begin
			out_s2 <= sat;
		end
	end

	// magnitudes; one extra bit keeps the negative limit and a+b exact
	always_comb begin
		a_ext   = MAG_W'(a_s1);
		b_ext   = MAG_W'(b_s1);
		sum_ab  = a_ext + b_ext;
		dif_ab  = a_ext - b_ext;
		mag_a   = mag_t'(a_ext[MAG_W-1] ? -a_ext : a_ext);
		mag_b   = mag_t'(b_ext[MAG_W-1] ? -b_ext : b_ext);
		mag_sum = mag_t'(sum_ab[MAG_W-1] ? -sum_ab : sum_ab);
		mag_dif = mag_t'(dif_ab[MAG_W-1] ? -dif_ab : dif_ab);
		mag_min = (mag_a > mag_b) ? mag_b : mag_a;
	end

	// a zero input gives a zero minimum, so the sign product needs no zero check
	always_comb begin
		neg      = a_s1[LLR_WIDTH-1] ^ b_s1[LLR_WIDTH-1];
		base     = neg ? -$signed(SUM_W'(mag_min)) : $signed(SUM_W'(mag_min));
		corr_sum = corr_of(mode_q, mag_sum);
		corr_dif = corr_of(mode_q, mag_dif);
		total    = base + $signed(SUM_W'(corr_sum)) - $signed(SUM_W'(corr_dif));
		if (total > SAT_HI) begin
			sat = LLR_WIDTH'(SAT_HI);
		end else if (total < SAT_LO) begin
			sat = LLR_WIDTH'(SAT_LO);
		end else begin
			sat = LLR_WIDTH'(total);
		end
	end

	assign out_valid = valid_s2;
	assign llr_out   = out_s2;

`ifndef SYNTHESIS
	// a stalled result must never be overwritten by the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(out_s2)))
		else $error("result register overwritten while stalled");

	// a held input request must stay in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(a_s1) && $stable(b_s1)))
		else $error("input register lost a pending request");

	// without correction the result is the plain min-sum term
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (mode_q == MODE_NONE || mode_q == MODE_RSVD)) |->
		(corr_sum == '0 && corr_dif == '0))
		else $error("correction applied with correction off");

	// a request accepted while the input register is full must move it on
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && valid_s1) |=> valid_s2)
		else $error("request dropped between stages");
`endif

endmodule

[sim/tb_boxplus_check_node_corrected.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_boxplus_check_node_corrected: self-checking bench for the box-plus node
// Drives pairs of LLRs through the valid/ready input with random gaps. It
// checks every result against a cycle-free model of the corrected min-sum
// check node under all four correction mode settings. It also forces a long
// result stall and mode changes at idle points.
// ----------------------------------------------------------------------------

module tb_boxplus_check_node_corrected;
	import bpcn_pkg::*;

	typedef logic signed [LLR_WIDTH-1:0] llr_t;

	class boxplus_scoreboard;
		corr_mode_t mode;
		llr_t       expected_llr_q[$];
		int         n_noted;
		int         n_checked;
		int         n_errors;

		function new();
			mode      = MODE_LIN;
			n_noted   = 0;
			n_checked = 0;
			n_errors  = 0;
		endfunction

		// k is in units of 1/10000; thresholds floor, levels round half up
		function longint fx_floor(longint k);
			return (k <<< FRAC_BITS) / 10000;
		endfunction

		function longint fx_round(longint k);
			return ((k <<< FRAC_BITS) + 5000) / 10000;
		endfunction

		function longint corr_term(longint mag);
			longint v;
			v = 0;
			if (mode == MODE_STEP) begin
				if (mag <= fx_floor(1960))
					v = fx_round(6500);
				else if (mag <= fx_floor(4330))
					v = fx_round(5500);
				else if (mag <= fx_floor(7100))
					v = fx_round(4500);
				else if (mag <= fx_floor(10500))
					v = fx_round(3500);
				else if (mag <= fx_floor(15080))
					v = fx_round(2500);
				else if (mag <= fx_floor(22520))
					v = fx_round(1500);
				else if (mag <= fx_floor(45000))
					v = fx_round(500);
			end else if (mode == MODE_LIN) begin
				if (mag <= fx_floor(5000))
					v = fx_round(7000) - (mag >>> 1);
				else if (mag <= fx_floor(16000))
					v = fx_round(5750) - (mag >>> 2);
				else if (mag <= fx_floor(22000))
					v = fx_round(3750) - (mag >>> 3);
				else if (mag <= fx_floor(32000))
					v = fx_round(2375) - (mag >>> 4);
				else if (mag <= fx_floor(44000))
					v = fx_round(1375) - (mag >>> 5);
				if (v < 0)
					v = 0;
			end
			return v;
		endfunction

		function llr_t boxplus_of(llr_t a, llr_t b);
			longint va, vb, ma, mb, lesser, ssum, sdif, r, top;
			va     = a;
			vb     = b;
			ma     = (va < 0) ? -va : va;
			mb     = (vb < 0) ? -vb : vb;
			lesser = (ma < mb) ? ma : mb;
			ssum   = va + vb;
			sdif   = va - vb;
			if (va == 0 || vb == 0)
				r = 0;
			else if ((va < 0) != (vb < 0))
				r = -lesser;
			else
				r = lesser;
			r   = r + corr_term((ssum < 0) ? -ssum : ssum)
				- corr_term((sdif < 0) ? -sdif : sdif);
			top = (longint'(1) <<< (LLR_WIDTH - 1)) - 1;
			if (r > top)
				r = top;
			if (r < -top - 1)
				r = -top - 1;
			return llr_t'(r);
		endfunction

		function void note_pair(llr_t a, llr_t b);
			expected_llr_q.push_back(boxplus_of(a, b));
			n_noted++;
		endfunction

		function void check_result(llr_t got);
			llr_t want;
			if (expected_llr_q.size() == 0) begin
				$error("llr_out: expected nothing, actual %0d", got);
				n_errors++;
				return;
			end
			want = expected_llr_q.pop_front();
			n_checked++;
			if (got !== want) begin
				n_errors++;
				$error("llr_out: expected %0d, actual %0d", want, got);
			end
		endfunction
	endclass

	// two register stages inside the block
	localparam int PIPE_LATENCY = 2;
	// worst case is far below this: ~1800 requests, idle_gap() idle cycles on each
	// side per request, one HOLD_CYCLES result hold and a few drains
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 700;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	llr_t       llr_a     = '0;
	llr_t       llr_b     = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	llr_t       llr_out;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_wdata = MODE_LIN;

	boxplus_scoreboard llr_sb = new();

	// when set, both sides run back to back with no idle cycles
	bit no_idle   = 1'b0;
	bit hold_done = 1'b0;
	int cycle_count;

	boxplus_check_node_corrected dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.llr_a     (llr_a),
		.llr_b     (llr_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.llr_out   (llr_out),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: end the run if the stream ever stops moving
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic int idle_gap();
		return no_idle ? 0 : $urandom_range(0, 15);
	endfunction

	// corner values: both rails, one inside each rail, around zero
	function automatic llr_t pick_corner();
		case ($urandom_range(0, 6))
			0: return llr_t'(-32768);
			1: return llr_t'(-32767);
			2: return llr_t'(-1);
			3: return llr_t'(0);
			4: return llr_t'(1);
			5: return llr_t'(32766);
			default: return llr_t'(32767);
		endcase
	endfunction

	// Mix the pairs so the correction tables get real work: |a+b| and |a-b|
	// only land inside the tables (below ~4.5) when the inputs are small or
	// nearly cancel, which plain full-range values almost never do.
	task automatic draw_pair(output llr_t a, output llr_t b);
		int     kind;
		longint base;
		kind = $urandom_range(0, 9);
		if (kind < 3) begin
			a = llr_t'($urandom_range(0, 2600) - 1300);
			b = llr_t'($urandom_range(0, 2600) - 1300);
		end else if (kind < 5) begin
			a    = llr_t'($urandom);
			base = $urandom_range(0, 1) ? longint'(a) : -longint'(a);
			b    = llr_t'(base + $urandom_range(0, 1200) - 600);
		end else if (kind == 5) begin
			a = pick_corner();
			b = pick_corner();
		end else begin
			a = llr_t'($urandom);
			b = llr_t'($urandom);
		end
	endtask

	// Offer one request after a random gap and hold it until taken. With no
	// gap, keep valid high so back-to-back requests stream through.
	task automatic send_pair(input llr_t a, input llr_t b);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		llr_a    <= a;
		llr_b    <= b;
		do @(posedge clk); while (!in_ready);
		llr_sb.note_pair(a, b);
	endtask

	task automatic send_random(input int count);
		llr_t a, b;
		repeat (count) begin
			draw_pair(a, b);
			send_pair(a, b);
		end
	endtask

	// Drop valid and wait for every outstanding result, then let the
	// pipeline settle before anything else happens.
	task automatic drain();
		in_valid <= 1'b0;
		while (llr_sb.expected_llr_q.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// Mode changes only at idle points so no request straddles them.
	task automatic set_mode(input corr_mode_t m);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		llr_sb.mode = m;
	endtask

	// Result side: random stall before each result, plus one long hold once
	// enough traffic has passed, so the pipe fills and backs up the input.
	initial begin : result_side
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = idle_gap();
			if (!hold_done && llr_sb.n_checked >= HOLD_AFTER) begin
				stall     = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			llr_sb.check_result(llr_out);
		end
	end

	initial begin : request_side
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset mode is piecewise linear. Hit the rails, zero inputs, both
		// inputs at the negative limit, and sums sitting on or just past the linear
		// band edges (0.5, 1.6, 2.2, 3.2, 4.4 in codes 128, 409, 563, 819, 1126).
		send_pair(0, 0);
		send_pair(0, -32768);
		send_pair(-32768, -32768);
		send_pair(32767, 32767);
		send_pair(-32768, 32767);
		send_pair(32767, -32768);
		send_pair(-1, -1);
		send_pair(1, -1);
		send_pair(256, -3);
		send_pair(64, 64);
		send_pair(65, 64);
		send_pair(205, 204);
		send_pair(205, 205);
		send_pair(282, 281);
		send_pair(282, 282);
		send_pair(410, 409);
		send_pair(563, 563);
		send_pair(-600, -527);

		// plain min-sum: the negative-limit pair must clip to the top rail
		set_mode(MODE_NONE);
		send_pair(-32768, -32768);
		send_pair(32767, 32767);
		send_pair(-32768, 1);
		send_pair(0, 12345);
		send_random(300);

		// reserved code behaves as no correction
		set_mode(MODE_RSVD);
		send_random(150);

		set_mode(MODE_STEP);
		send_random(450);

		set_mode(MODE_LIN);
		send_random(250);
		// a stretch with no idle cycles on either side
		no_idle = 1'b1;
		send_random(200);
		no_idle = 1'b0;

		set_mode(MODE_STEP);
		send_random(200);

		set_mode(MODE_NONE);
		send_random(100);

		set_mode(MODE_LIN);
		send_random(120);

		drain();
		$display("Checked %0d box-plus results from %0d requests under no, step, linear and",
			llr_sb.n_checked, llr_sb.n_noted);
		$display("reserved correction modes, including rail saturation and a %0d-cycle stall.",
			HOLD_CYCLES);
		if (llr_sb.n_errors == 0 && llr_sb.expected_llr_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[sim.f]
design/bpcn_pkg.sv
design/boxplus_check_node_corrected.sv
sim/tb_boxplus_check_node_corrected.sv
